/* sv/snp_pkg.sv */
// Shared types, codes and widths for the selection network programmer.
// Used by the controller, the datapath, the top level and the port checker.
// No dependencies.
`default_nettype none

package snp_pkg;

	localparam int MAX_PORTS_DEF = 32;

	localparam int TGT_W     = 5;
	localparam int SLOT_W    = 5;
	localparam int CFG_W     = 6;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_INPUT_COUNT  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_COUNT = 1'b1;

	localparam logic FUNC_ENTRY = 1'b0;

	typedef struct packed {
		logic             func;
		logic [TGT_W-1:0] target_input;
		logic             last_entry;
	} entry_t;

	typedef struct packed {
		logic [SLOT_W-1:0] slot_index;
		logic [SLOT_W-1:0] first_route;
		logic              first_valid;
		logic              gate_bit;
		logic              gate_valid;
		logic [SLOT_W-1:0] second_route;
		logic              second_valid;
		logic              bypass;
		logic              error;
		logic              last_result;
	} result_t;

	// Datapath operation for the current cycle.
	typedef enum logic [3:0] {
		OP_LOAD,
		OP_CNT_RD,
		OP_CNT_LOOK,
		OP_CNT_UPD,
		OP_PRE_RD,
		OP_PRE_UPD,
		OP_SLT_RD,
		OP_SLT_UPD,
		OP_SEC_RD,
		OP_SEC_LOOK,
		OP_SEC_UPD,
		OP_OUT_RD,
		OP_OUT_LD,
		OP_SINGLE
	} op_t;

	typedef struct packed {
		op_t  op;
		logic clr_idx;
		logic inc_idx;
	} cmd_t;

	typedef struct packed {
		logic at_end;
		logic run_err;
		logic ni_one;
		logic ni_gt_no;
		logic out_free;
		logic last_accept;
	} status_t;

endpackage

`default_nettype wire

/* sv/snp_ctrl.sv */
// Pass sequencer of the selection network programmer.
// Depends on snp_pkg for the command and status structs.
`default_nettype none

module snp_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  snp_pkg::status_t status,
	output snp_pkg::cmd_t    cmd
);
	import snp_pkg::*;

	typedef enum logic [13:0] {
		S_LOAD     = 14'b00000000000001,
		S_CNT_RD   = 14'b00000000000010,
		S_CNT_LOOK = 14'b00000000000100,
		S_CNT_UPD  = 14'b00000000001000,
		S_PRE_RD   = 14'b00000000010000,
		S_PRE_UPD  = 14'b00000000100000,
		S_SLT_RD   = 14'b00000001000000,
		S_SLT_UPD  = 14'b00000010000000,
		S_SEC_RD   = 14'b00000100000000,
		S_SEC_LOOK = 14'b00001000000000,
		S_SEC_UPD  = 14'b00010000000000,
		S_OUT_RD   = 14'b00100000000000,
		S_OUT_LD   = 14'b01000000000000,
		S_SINGLE   = 14'b10000000000000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		cmd.op      = OP_LOAD;
		cmd.clr_idx = 1'b0;
		cmd.inc_idx = 1'b0;
		unique case (state_q)
			S_LOAD: begin
				cmd.op = OP_LOAD;
				if (status.last_accept) begin
					cmd.clr_idx = 1'b1;
					state_d     = S_CNT_RD;
				end
			end
			S_CNT_RD: begin
				cmd.op  = OP_CNT_RD;
				state_d = S_CNT_LOOK;
			end
			S_CNT_LOOK: begin
				cmd.op  = OP_CNT_LOOK;
				state_d = S_CNT_UPD;
			end
			S_CNT_UPD: begin
				cmd.op = OP_CNT_UPD;
				if (status.at_end) begin
					cmd.clr_idx = 1'b1;
					// Failed runs, the single-input case and more inputs than outputs end in one result.
					if (status.run_err || status.ni_one || status.ni_gt_no) begin
						state_d = S_SINGLE;
					end else begin
						state_d = S_PRE_RD;
					end
				end else begin
					cmd.inc_idx = 1'b1;
					state_d     = S_CNT_RD;
				end
			end
			S_PRE_RD: begin
				cmd.op  = OP_PRE_RD;
				state_d = S_PRE_UPD;
			end
			S_PRE_UPD: begin
				cmd.op = OP_PRE_UPD;
				if (status.at_end) begin
					cmd.clr_idx = 1'b1;
					state_d     = S_SLT_RD;
				end else begin
					cmd.inc_idx = 1'b1;
					state_d     = S_PRE_RD;
				end
			end
			S_SLT_RD: begin
				cmd.op  = OP_SLT_RD;
				state_d = S_SLT_UPD;
			end
			S_SLT_UPD: begin
				cmd.op = OP_SLT_UPD;
				if (status.at_end) begin
					cmd.clr_idx = 1'b1;
					state_d     = S_SEC_RD;
				end else begin
					cmd.inc_idx = 1'b1;
					state_d     = S_SLT_RD;
				end
			end
			S_SEC_RD: begin
				cmd.op  = OP_SEC_RD;
				state_d = S_SEC_LOOK;
			end
			S_SEC_LOOK: begin
				cmd.op  = OP_SEC_LOOK;
				state_d = S_SEC_UPD;
			end
			S_SEC_UPD: begin
				cmd.op = OP_SEC_UPD;
				if (status.at_end) begin
					cmd.clr_idx = 1'b1;
					state_d     = S_OUT_RD;
				end else begin
					cmd.inc_idx = 1'b1;
					state_d     = S_SEC_RD;
				end
			end
			S_OUT_RD: begin
				cmd.op  = OP_OUT_RD;
				state_d = S_OUT_LD;
			end
			S_OUT_LD: begin
				cmd.op = OP_OUT_LD;
				if (status.out_free) begin
					if (status.at_end) begin
						cmd.clr_idx = 1'b1;
						state_d     = S_LOAD;
					end else begin
						cmd.inc_idx = 1'b1;
						state_d     = S_OUT_RD;
					end
				end
			end
			S_SINGLE: begin
				cmd.op = OP_SINGLE;
				if (status.out_free) begin
					state_d = S_LOAD;
				end
			end
			default: begin
				state_d = S_LOAD;
			end
		endcase
	end

endmodule

`default_nettype wire

/* sv/snp_datapath.sv */
// Datapath of the selection network programmer: configuration registers,
// entry and program memories, pass counters and the result register.
// Depends on snp_pkg; driven by commands from snp_ctrl.
`default_nettype none

module snp_datapath #(
	parameter int MAX_PORTS = snp_pkg::MAX_PORTS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [snp_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [snp_pkg::CFG_W-1:0]            cfg_data,
	input  logic                                 entry_valid,
	output logic                                 entry_ready,
	input  snp_pkg::entry_t                      entry,
	output logic                                 result_valid,
	input  logic                                 result_ready,
	output snp_pkg::result_t                     result,
	input  snp_pkg::cmd_t                        cmd,
	output snp_pkg::status_t                     status
);
	import snp_pkg::*;

	localparam int AW = $clog2(MAX_PORTS);
	localparam int CW = $clog2(MAX_PORTS + 1);
	localparam int EW = (CW > TGT_W) ? CW : TGT_W;
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_PORTS);

	function automatic logic [CW-1:0] clamp_count(input logic [CFG_W-1:0] v);
		logic [CW-1:0] c;
		if (v == '0) begin
			c = CW'(1);
		end else if (int'(v) > MAX_PORTS) begin
			c = MAX_CNT;
		end else begin
			c = CW'(v);
		end
		return c;
	endfunction

	// Configuration
	logic [CFG_W-1:0] input_count_q;
	logic [CFG_W-1:0] output_count_q;
	logic [CW-1:0]    ni;
	logic [CW-1:0]    no;

	// Load and run control
	logic [CW-1:0] load_count_q;
	logic          error_seen_q;
	logic [CW-1:0] run_len_q;
	logic          err_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] idx_inc;
	logic [AW-1:0] idx_a;
	logic [CW-1:0] sum_q;
	logic [CW-1:0] nu_q;
	logic [CW-1:0] k_q;
	logic [MAX_PORTS-1:0] cvalid_q;
	logic [MAX_PORTS-1:0] gate_q;

	logic          entry_acc;
	logic          is_entry;
	logic          room;
	logic          entry_we;
	logic          last_acc;
	logic [CW-1:0] lc_new;
	logic          e_ok;
	logic          used;
	logic          take;
	logic          at_end;

	// Memories and their registered read data
	logic [TGT_W-1:0] entry_mem_q  [MAX_PORTS];
	logic [CW-1:0]    count_mem_q  [MAX_PORTS];
	logic [AW-1:0]    gnext_mem_q  [MAX_PORTS];
	logic [AW-1:0]    first_mem_q  [MAX_PORTS];
	logic [AW-1:0]    unused_mem_q [MAX_PORTS];
	logic [AW-1:0]    second_mem_q [MAX_PORTS];

	logic [TGT_W-1:0] entry_rd_q;
	logic [CW-1:0]    count_rd_q;
	logic [AW-1:0]    gnext_rd_q;
	logic [AW-1:0]    first_rd_q;
	logic [AW-1:0]    unused_rd_q;
	logic [AW-1:0]    second_rd_q;

	logic [AW-1:0] e_q;
	logic          e_ok_q;

	logic [AW-1:0] cnt_ra;
	logic          cnt_we;
	logic [CW-1:0] cnt_wd;
	logic          first_we;
	logic [AW-1:0] first_wa;
	logic [AW-1:0] first_wd;
	logic          gnext_we;
	logic [AW-1:0] gnext_wa;
	logic [AW-1:0] gnext_wd;
	logic          unused_we;
	logic          second_we;

	// Result register
	logic    result_valid_q;
	result_t result_q;
	result_t res_d;
	logic    out_free;
	logic    load_out;
	logic    fv;
	logic    gv;
	logic    single_err;

	assign ni = clamp_count(input_count_q);
	assign no = clamp_count(output_count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			input_count_q  <= CFG_W'(1);
			output_count_q <= CFG_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_INPUT_COUNT:  input_count_q  <= cfg_data;
				REG_OUTPUT_COUNT: output_count_q <= cfg_data;
			endcase
		end
	end

	assign entry_ready = (cmd.op == OP_LOAD);
	assign entry_acc   = entry_valid && entry_ready;
	assign is_entry    = entry_acc && (entry.func == FUNC_ENTRY);
	assign room        = (load_count_q < MAX_CNT);
	assign entry_we    = is_entry && room;
	assign last_acc    = is_entry && entry.last_entry;
	assign lc_new      = room ? (load_count_q + CW'(1)) : MAX_CNT;

	assign idx_inc = idx_q + CW'(1);
	assign idx_a   = idx_q[AW-1:0];

	assign e_ok = (EW'(entry_rd_q) < EW'(ni));
	assign used = cvalid_q[idx_a];
	// A slot whose left gate bit is clear repeats its neighbor, so it is free.
	assign take = !gate_q[idx_a] && (k_q < nu_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_count_q <= '0;
			error_seen_q <= 1'b0;
			run_len_q    <= '0;
			err_q        <= 1'b0;
		end else begin
			if (last_acc) begin
				load_count_q <= '0;
				error_seen_q <= 1'b0;
				run_len_q    <= lc_new;
				err_q        <= error_seen_q || !room || (lc_new != no);
			end else begin
				if (entry_we) begin
					load_count_q <= load_count_q + CW'(1);
				end else if (is_entry) begin
					error_seen_q <= 1'b1;
				end
				if ((cmd.op == OP_CNT_LOOK) && !e_ok) begin
					err_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			sum_q    <= '0;
			nu_q     <= '0;
			k_q      <= '0;
			cvalid_q <= '0;
			gate_q   <= '0;
		end else begin
			if (cmd.clr_idx) begin
				idx_q <= '0;
			end else if (cmd.inc_idx) begin
				idx_q <= idx_inc;
			end
			if (last_acc) begin
				sum_q    <= '0;
				nu_q     <= '0;
				k_q      <= '0;
				cvalid_q <= '0;
				gate_q   <= '0;
			end else begin
				if (cnt_we) begin
					cvalid_q[e_q] <= 1'b1;
				end
				if (cmd.op == OP_PRE_UPD) begin
					if (used) begin
						sum_q <= sum_q + count_rd_q;
						if (sum_q != '0) begin
							gate_q[AW'(sum_q - CW'(1))] <= 1'b1;
						end
					end else begin
						nu_q <= nu_q + CW'(1);
					end
				end
				if ((cmd.op == OP_SLT_UPD) && take) begin
					k_q <= k_q + CW'(1);
				end
			end
		end
	end

	// The looked-up entry and its range check are registered for the update step's writes.
	always_ff @(posedge clk) begin
		e_q    <= AW'(entry_rd_q);
		e_ok_q <= e_ok;
	end

	always_comb begin
		cnt_ra    = (cmd.op == OP_CNT_LOOK) ? AW'(entry_rd_q) : idx_a;
		cnt_we    = (cmd.op == OP_CNT_UPD) && e_ok_q;
		cnt_wd    = (cvalid_q[e_q] ? count_rd_q : '0) + CW'(1);
		first_we  = 1'b0;
		first_wa  = idx_a;
		first_wd  = sum_q[AW-1:0];
		gnext_we  = 1'b0;
		gnext_wa  = idx_a;
		gnext_wd  = sum_q[AW-1:0];
		unused_we = (cmd.op == OP_PRE_UPD) && !used;
		second_we = (cmd.op == OP_SEC_UPD);
		if ((cmd.op == OP_PRE_UPD) && used) begin
			first_we = 1'b1;
			gnext_we = 1'b1;
		end
		if ((cmd.op == OP_SLT_UPD) && take) begin
			first_we = 1'b1;
			first_wa = unused_rd_q;
			first_wd = AW'(idx_inc);
		end
		if (cmd.op == OP_SEC_UPD) begin
			gnext_we = 1'b1;
			gnext_wa = e_q;
			gnext_wd = gnext_rd_q + AW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (entry_we) begin
			entry_mem_q[load_count_q[AW-1:0]] <= entry.target_input;
		end
		entry_rd_q <= entry_mem_q[idx_a];
	end

	always_ff @(posedge clk) begin
		if (cnt_we) begin
			count_mem_q[e_q] <= cnt_wd;
		end
		count_rd_q <= count_mem_q[cnt_ra];
	end

	always_ff @(posedge clk) begin
		if (gnext_we) begin
			gnext_mem_q[gnext_wa] <= gnext_wd;
		end
		gnext_rd_q <= gnext_mem_q[AW'(entry_rd_q)];
	end

	always_ff @(posedge clk) begin
		if (first_we) begin
			first_mem_q[first_wa] <= first_wd;
		end
		first_rd_q <= first_mem_q[idx_a];
	end

	always_ff @(posedge clk) begin
		if (unused_we) begin
			unused_mem_q[nu_q[AW-1:0]] <= idx_a;
		end
		unused_rd_q <= unused_mem_q[k_q[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (second_we) begin
			second_mem_q[gnext_rd_q] <= idx_a;
		end
		second_rd_q <= second_mem_q[idx_a];
	end

	assign out_free   = !result_valid_q || result_ready;
	assign load_out   = ((cmd.op == OP_OUT_LD) || (cmd.op == OP_SINGLE)) && out_free;
	assign fv         = (idx_q < ni);
	assign gv         = (idx_inc < no);
	assign single_err = err_q || (ni > no);

	always_comb begin
		res_d = '0;
		if (cmd.op == OP_SINGLE) begin
			res_d.error       = single_err;
			res_d.bypass      = !single_err;
			res_d.last_result = 1'b1;
		end else begin
			res_d.slot_index   = SLOT_W'(idx_q);
			res_d.first_route  = fv ? SLOT_W'(first_rd_q) : '0;
			res_d.first_valid  = fv;
			res_d.gate_bit     = gv && gate_q[idx_a];
			res_d.gate_valid   = gv;
			res_d.second_route = SLOT_W'(second_rd_q);
			res_d.second_valid = 1'b1;
			res_d.last_result  = (idx_inc == no);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (load_out) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			result_q <= res_d;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	always_comb begin
		unique case (cmd.op)
			OP_CNT_UPD:             at_end = (idx_inc == run_len_q);
			OP_PRE_UPD:             at_end = (idx_inc == ni);
			OP_SLT_UPD:             at_end = ((idx_inc + CW'(1)) == no);
			OP_SEC_UPD, OP_OUT_LD:  at_end = (idx_inc == no);
			default:                at_end = 1'b0;
		endcase
	end

	assign status = '{
		at_end:      at_end,
		run_err:     err_q,
		ni_one:      (ni == CW'(1)),
		ni_gt_no:    (ni > no),
		out_free:    out_free,
		last_accept: last_acc
	};

endmodule

`default_nettype wire

/* sv/selection_network_programmer_core.sv */
// Top level of the selection network programmer.
// Depends on snp_pkg, snp_ctrl and snp_datapath.
//
//   Channel   Signals                                  Transaction
//   entry     entry_valid / entry_ready / entry        one selection entry
//   result    result_valid / result_ready / result     one program result
//   config    cfg_we / cfg_index / cfg_data            one register write
//
// Entries load at one per cycle while entry_ready is high; at most MAX_PORTS
// are kept. After the last entry, with clamped counts NI and NO, a good run
// does counting (read, look-up, update per entry), prefix and free-slot (read,
// update per input, per output but the last) and inverse (read, look-up,
// update per output) passes, then reads and loads each result; each step is
// bound by a registered memory read. A failed, single-input or NI > NO run
// gives one result. Reset clears control state, use valid bits and gate bits
// at once; there is no clearing pass. A result waits in the output register;
// entry_ready stays low from the last entry until the final result is loaded.
`default_nettype none

module selection_network_programmer_core #(
	parameter int MAX_PORTS = snp_pkg::MAX_PORTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [snp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [snp_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          entry_valid,
	output logic                          entry_ready,
	input  snp_pkg::entry_t               entry,
	output logic                          result_valid,
	input  logic                          result_ready,
	output snp_pkg::result_t              result
);
	import snp_pkg::*;

	cmd_t    cmd;
	status_t status;

	snp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.cmd    (cmd)
	);

	snp_datapath #(
		.MAX_PORTS (MAX_PORTS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.entry_valid  (entry_valid),
		.entry_ready  (entry_ready),
		.entry        (entry),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cmd          (cmd),
		.status       (status)
	);

endmodule

`default_nettype wire

/* sv/snp_checker.sv */
// Port-level checks for the selection network programmer, bound to the top.
// Depends on snp_pkg and selection_network_programmer_core.
`default_nettype none

module snp_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             entry_valid,
	input logic             entry_ready,
	input snp_pkg::entry_t  entry,
	input logic             result_valid,
	input logic             result_ready,
	input snp_pkg::result_t result
);
	import snp_pkg::*;

	// A stalled result transaction keeps its payload.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// The final entry starts the passes, so no entry is taken next cycle.
	a_run_busy: assert property (@(posedge clk) disable iff (!arst_n)
		entry_valid && entry_ready && (entry.func == FUNC_ENTRY) && entry.last_entry
		|=> !entry_ready)
		else $error("entry accepted right after the final entry");

	// While a run still has results to give, no new entry is taken.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.last_result |-> !entry_ready)
		else $error("entry port open during result output");

	// Error and bypass results stand alone and carry no program.
	a_single_form: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.bypass || result.error)
		|-> result.last_result && (result.slot_index == '0) && !result.first_valid
			&& !result.second_valid && !result.gate_valid)
		else $error("malformed single result");

endmodule

bind selection_network_programmer_core snp_checker u_snp_checker (.*);

`default_nettype wire
